// ----- rtl/tptc_pkg.sv -----
// Shared types and constants for the tile pixel tolerance compare block.
// Holds the transfer payload structs and the stage struct between the
// distance unit and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tptc_pkg;

    localparam int CHAN_W = 8;
    localparam int THR_W  = 17;
    localparam int SQ_W   = 2 * CHAN_W;
    // Three squares of 8-bit differences need 18 bits.
    localparam int D2_W   = SQ_W + 2;
    localparam int TSQ_W  = 2 * THR_W;

    typedef struct packed {
        logic [CHAN_W-1:0] old_red;
        logic [CHAN_W-1:0] old_green;
        logic [CHAN_W-1:0] old_blue;
        logic [CHAN_W-1:0] old_alpha;
        logic [CHAN_W-1:0] new_red;
        logic [CHAN_W-1:0] new_green;
        logic [CHAN_W-1:0] new_blue;
        logic [CHAN_W-1:0] new_alpha;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic tiles_match;
        logic old_all_transparent;
        logic new_all_transparent;
    } t_out_item;

    typedef struct packed {
        logic [D2_W-1:0]   d2;
        logic [CHAN_W-1:0] da;
        logic              old_opaque;
        logic              new_opaque;
        logic              last;
    } t_pair_eval;

endpackage

`default_nettype wire

// ----- rtl/tptc_pair_dist.sv -----
// Squared RGB distance and absolute alpha difference of one pixel pair.
// Pure combinational; uses tptc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tptc_pair_dist
    import tptc_pkg::*;
(
    input  var t_in_item   i_pair,
    output var t_pair_eval o_eval
);

    logic [CHAN_W-1:0] d_r;
    logic [CHAN_W-1:0] d_g;
    logic [CHAN_W-1:0] d_b;
    logic [SQ_W-1:0]   sq_r;
    logic [SQ_W-1:0]   sq_g;
    logic [SQ_W-1:0]   sq_b;

    function automatic logic [CHAN_W-1:0] abs_diff(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        d_r  = abs_diff(i_pair.old_red,   i_pair.new_red);
        d_g  = abs_diff(i_pair.old_green, i_pair.new_green);
        d_b  = abs_diff(i_pair.old_blue,  i_pair.new_blue);
        sq_r = SQ_W'(d_r) * SQ_W'(d_r);
        sq_g = SQ_W'(d_g) * SQ_W'(d_g);
        sq_b = SQ_W'(d_b) * SQ_W'(d_b);

        o_eval.d2         = D2_W'(sq_r) + D2_W'(sq_g) + D2_W'(sq_b);
        o_eval.da         = abs_diff(i_pair.old_alpha, i_pair.new_alpha);
        o_eval.old_opaque = |i_pair.old_alpha;
        o_eval.new_opaque = |i_pair.new_alpha;
        o_eval.last       = i_pair.last;
    end

endmodule

`default_nettype wire

// ----- rtl/tile_pixel_tolerance_compare.sv -----
// Top level of the tile pixel tolerance compare block.
// Depends on tptc_pkg and tptc_pair_dist.
//
//  Channel  | Signals                            | Payload
//  ---------+------------------------------------+-----------------------------
//  pair in  | i_in_valid / o_in_ready            | i_in_data  (t_in_item)
//  result   | o_out_valid / i_out_ready          | o_out_data (t_out_item)
//  config   | i_cfg_we (no wait)                 | i_cfg_wdata (threshold, Q8)
//
// One pixel pair is accepted per cycle while o_in_ready is high. A pair
// passes an input register, a stage that squares the channel differences,
// and a compare/flag stage that registers a last pair's result on o_out_valid.
// The squared threshold is formed when the register is written.
// Synchronous active-low reset empties the pipeline and clears the threshold.
// Pairs that are not last keep flowing while a result waits on i_out_ready;
// only a last pair stalls behind an untaken result.
`timescale 1ns / 1ps
`default_nettype none

module tile_pixel_tolerance_compare
    import tptc_pkg::*;
(
    input  var logic              i_clk,
    input  var logic              i_rst_n,
    input  var logic              i_cfg_we,
    input  var logic [THR_W-1:0]  i_cfg_wdata,
    input  var logic              i_in_valid,
    output var logic              o_in_ready,
    input  var t_in_item          i_in_data,
    output var logic              o_out_valid,
    input  var logic              i_out_ready,
    output var t_out_item         o_out_data
);

    logic [THR_W-1:0] r_threshold;
    logic [TSQ_W-1:0] r_t_sq;
    logic [TSQ_W-1:0] n_t_sq;

    logic       r_s1_valid;
    t_in_item   r_s1;
    logic       r_s2_valid;
    t_pair_eval r_s2;
    t_pair_eval s1_eval;

    logic       r_old_tr;
    logic       r_new_tr;
    logic       r_mismatch;
    logic       n_old_tr;
    logic       n_new_tr;
    logic       n_mismatch;

    logic       r_out_valid;
    t_out_item  r_out;

    logic       out_free;
    logic       s2_adv;
    logic       s2_free;
    logic       s1_adv;
    logic       s1_free;
    logic       rgb_ok;
    logic       alpha_ok;

    tptc_pair_dist u_pair_dist (
        .i_pair (r_s1),
        .o_eval (s1_eval)
    );

    assign n_t_sq = {{(TSQ_W-THR_W){1'b0}}, i_cfg_wdata}
                  * {{(TSQ_W-THR_W){1'b0}}, i_cfg_wdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_t_sq      <= '0;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
            r_t_sq      <= n_t_sq;
        end
    end

    // A last pair may only leave stage 2 when the result register is free.
    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        s2_adv     = r_s2_valid && (!r_s2.last || out_free);
        s2_free    = !r_s2_valid || s2_adv;
        s1_adv     = r_s1_valid && s2_free;
        s1_free    = !r_s1_valid || s1_adv;
        o_in_ready = s1_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_free) begin
                r_s2_valid <= s1_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in_valid) begin
            r_s1 <= i_in_data;
        end
        if (s1_adv) begin
            r_s2 <= s1_eval;
        end
    end

    always_comb begin
        rgb_ok     = {r_s2.d2, {(TSQ_W-D2_W){1'b0}}} <= r_t_sq;
        alpha_ok   = {{(THR_W-SQ_W){1'b0}}, r_s2.da, {CHAN_W{1'b0}}} <= r_threshold;
        n_old_tr   = r_old_tr && !r_s2.old_opaque;
        n_new_tr   = r_new_tr && !r_s2.new_opaque;
        n_mismatch = r_mismatch || !(rgb_ok && alpha_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_tr   <= 1'b1;
            r_new_tr   <= 1'b1;
            r_mismatch <= 1'b0;
        end else if (s2_adv) begin
            if (r_s2.last) begin
                r_old_tr   <= 1'b1;
                r_new_tr   <= 1'b1;
                r_mismatch <= 1'b0;
            end else begin
                r_old_tr   <= n_old_tr;
                r_new_tr   <= n_new_tr;
                r_mismatch <= n_mismatch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv && r_s2.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s2.last) begin
            r_out.tiles_match         <= (n_old_tr && n_new_tr) || !n_mismatch;
            r_out.old_all_transparent <= n_old_tr;
            r_out.new_all_transparent <= n_new_tr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A last pair leaving stage 2 always lands in the result register.
    a_last_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_adv && r_s2.last |=> r_out_valid)
        else $error("last pair left stage 2 without a result");

    // Tile state is back at its start values after a last pair.
    a_tile_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_adv && r_s2.last |=> r_old_tr && r_new_tr && !r_mismatch)
        else $error("tile state not restored after last pair");

    // An untaken result must not be overwritten by a new one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !(s2_adv && r_s2.last))
        else $error("pending result overwritten");

    // Two transparent tiles always report a match.
    a_transparent_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.old_all_transparent && r_out.new_all_transparent
            |-> r_out.tiles_match)
        else $error("transparent tiles reported as mismatch");

    // An empty input register never refuses a transfer.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_in_ready)
        else $error("input stalled with empty input register");

endmodule

`default_nettype wire
